[rtl/swm_pkg.sv]
package swm_pkg;

    localparam int CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd1;

    // per-cycle command shared by every cell of the chain
    typedef struct packed {
        logic step;    // a word is taken this cycle
        logic trim;    // drop the front candidate, no word taken
        logic shift;   // front candidate leaves the window on this step
        logic clear;   // history is thrown away before the word
        logic append;  // the new sample joins the chain
    } swm_ctl_t;

endpackage

[rtl/sliding_window_maximum.sv]
// output: window_max is registered and shows in the cycle after its sample word is taken
// throughput: one word per cycle while results are taken at once and no trim is pending; a held result stalls input
// a shrunk window retires the candidates already outside it one by one, stalling input, before the next word
// the chain of candidate cells compares every candidate against the sample in parallel
// reset: chain empty, sample count zero, window_size back to one, no result pending
module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    start_sequence,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [SAMPLE_WIDTH-1:0] window_max,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_WIDTH-1:0]    window_size
);

    localparam int AW = $clog2(MAX_WINDOW + 1);
    localparam int CW = ((AW > CFG_WIDTH) ? AW : CFG_WIDTH) + 1;

    logic [CFG_WIDTH-1:0]    window_reg;
    logic [AW-1:0]           seen_reg;
    logic [AW-1:0]           seen_next;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic [SAMPLE_WIDTH-1:0] window_max_reg;

    logic [CW-1:0] w_eff;
    logic [CW-1:0] seen_clamp;
    logic [CW-1:0] seen_inc;
    logic          trim;
    logic          in_acc;
    logic          produce;
    swm_ctl_t      ctl;

    logic [MAX_WINDOW:0]     cv;
    logic [SAMPLE_WIDTH-1:0] cval [0:MAX_WINDOW];
    logic [AW-1:0]           cage [0:MAX_WINDOW];
    logic [MAX_WINDOW:0]     keptc;
    logic [SAMPLE_WIDTH-1:0] head_next [0:MAX_WINDOW-1];

    assign cv[MAX_WINDOW]   = 1'b0;
    assign cval[MAX_WINDOW] = '0;
    assign cage[MAX_WINDOW] = '0;
    assign keptc[0]         = 1'b1;

    always_comb
    begin
        w_eff = (CW'(window_reg) > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(window_reg);
        // front candidate already outside a shrunk window, retired only once a word waits
        trim = sample_valid && cv[0] && (CW'(cage[0]) >= w_eff) && (w_eff != '0);
        sample_stall = trim || (result_valid_reg && result_stall);
        in_acc = sample_valid && !sample_stall;

        ctl.step   = in_acc;
        ctl.trim   = trim;
        ctl.clear  = start_sequence || (w_eff == '0);
        ctl.append = (w_eff != '0);
        ctl.shift  = in_acc && !ctl.clear && cv[0] && ((CW'(cage[0]) + CW'(1)) >= w_eff);

        seen_clamp = start_sequence ? '0 : CW'(seen_reg);
        if (seen_clamp > w_eff)
        begin
            seen_clamp = w_eff;
        end
        seen_inc = (seen_clamp < w_eff) ? seen_clamp + CW'(1) : seen_clamp;
        produce  = (w_eff != '0) && (seen_inc >= w_eff);

        seen_next = seen_reg;
        if (in_acc)
        begin
            seen_next = (w_eff == '0) ? '0 : AW'(seen_inc);
        end

        result_valid_next = result_valid_reg;
        if (in_acc)
        begin
            result_valid_next = produce;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            swm_cell #(
                .SAMPLE_WIDTH(SAMPLE_WIDTH),
                .AGE_WIDTH(AW)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctl(ctl),
                .sample(sample),
                .next_valid(cv[gi+1]),
                .next_value(cval[gi+1]),
                .next_age(cage[gi+1]),
                .kept_prev(keptc[gi]),
                .valid(cv[gi]),
                .value(cval[gi]),
                .age(cage[gi]),
                .kept(keptc[gi+1]),
                .value_next(head_next[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= WINDOW_RESET;
            seen_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= window_size;
            end
            seen_reg         <= seen_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // the head cell holds the oldest candidate, which is the window maximum
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            window_max_reg <= head_next[0];
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign window_max   = window_max_reg;

    // occupied cells always form a run starting at the head
    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cv[MAX_WINDOW-1:0] + MAX_WINDOW'(1)) & cv[MAX_WINDOW-1:0]) == '0)
        else $error("candidate chain has a gap");

    // a new result only ever follows a taken word
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_acc && !result_valid_reg) |=> !result_valid_reg)
        else $error("result appeared without a word");

    // a disabled window leaves no history behind
    a_zero_window: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (w_eff == '0)) |=> (cv[MAX_WINDOW-1:0] == '0) && (seen_reg == '0))
        else $error("history kept with zero window");

    // a sequence start leaves only the new sample in the chain
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && start_sequence && (w_eff != '0)) |=> (cv[MAX_WINDOW-1:0] == MAX_WINDOW'(1)))
        else $error("sequence start did not clear chain");

endmodule

[rtl/swm_cell.sv]
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int AGE_WIDTH = 7
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  swm_ctl_t                ctl,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    next_valid,
    input  logic [SAMPLE_WIDTH-1:0] next_value,
    input  logic [AGE_WIDTH-1:0]    next_age,
    input  logic                    kept_prev,
    output logic                    valid,
    output logic [SAMPLE_WIDTH-1:0] value,
    output logic [AGE_WIDTH-1:0]    age,
    output logic                    kept,
    output logic [SAMPLE_WIDTH-1:0] value_next
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [SAMPLE_WIDTH-1:0] value_reg;
    logic [AGE_WIDTH-1:0]    age_reg;
    logic [AGE_WIDTH-1:0]    age_next;
    logic                    src_valid;
    logic [SAMPLE_WIDTH-1:0] src_value;
    logic [AGE_WIDTH-1:0]    src_age;

    always_comb
    begin
        src_valid = ctl.shift ? next_valid : valid_reg;
        src_value = ctl.shift ? next_value : value_reg;
        src_age   = ctl.shift ? next_age   : age_reg;
        // a candidate survives only if it is strictly greater than the new sample
        kept = src_valid && !ctl.clear && ($signed(src_value) > $signed(sample));

        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctl.trim)
        begin
            valid_next = next_valid;
            value_next = next_value;
            age_next   = next_age;
        end
        else if (ctl.step)
        begin
            if (kept)
            begin
                valid_next = 1'b1;
                value_next = src_value;
                age_next   = src_age + AGE_WIDTH'(1);
            end
            else if (kept_prev && ctl.append)
            begin
                // first free slot after the surviving candidates
                valid_next = 1'b1;
                value_next = sample;
                age_next   = '0;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule
